/* src/assert_macros.svh */
// Assertion macros shared by the checker modules of this block.
// Needs no package; the caller supplies clock, reset, property and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hrp_pkg.sv */
// Shared types and constants for the hold-repeat paging block.
// No dependencies.
`default_nettype none

package hrp_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int CSR_DATA_WIDTH     = 16;
   localparam int PAGE_WIDTH         = 8;

   typedef logic [1:0] dir_type;
   localparam dir_type DIR_NONE     = 2'd0;
   localparam dir_type DIR_FORWARD  = 2'd1;
   localparam dir_type DIR_BACKWARD = 2'd2;
   localparam dir_type DIR_INVALID  = 2'd3;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_ENTER_HOLD_TIME  = 1'd0;
   localparam csr_index_type CSR_REPEAT_PAGE_STEP = 1'd1;

   localparam logic [15:0] ENTER_HOLD_RESET  = 16'd500;
   localparam logic [7:0]  REPEAT_STEP_RESET = 8'd10;

   // hold-time tiers and the repeat interval that goes with each
   localparam logic [15:0] HELD_TIER_1 = 16'd5000;
   localparam logic [15:0] HELD_TIER_2 = 16'd10000;
   localparam logic [15:0] HELD_TIER_3 = 16'd20000;
   localparam logic [8:0]  INTERVAL_0  = 9'd360;
   localparam logic [8:0]  INTERVAL_1  = 9'd300;
   localparam logic [8:0]  INTERVAL_2  = 9'd240;
   localparam logic [8:0]  INTERVAL_3  = 9'd200;

   typedef struct packed {
      logic    pending;
      logic    active;
      dir_type dir;
   } flags_type;

   typedef struct packed {
      logic                  turn;
      dir_type               dir;
      logic [PAGE_WIDTH-1:0] pages;
   } result_type;

endpackage

`default_nettype wire

/* src/hrp_step.sv */
// Next-state and result logic for one button sample.
// Depends on hrp_pkg.
`default_nettype none

module hrp_step #(
   parameter int TIME_WIDTH = hrp_pkg::TIME_WIDTH_DEFAULT
) (
   input  hrp_pkg::flags_type       cur_flags,
   input  logic [TIME_WIDTH-1:0]    cur_last,
   input  logic                     press_edge,
   input  logic                     release_edge,
   input  logic                     button_down,
   input  hrp_pkg::dir_type         press_direction,
   input  logic [TIME_WIDTH-1:0]    held_time,
   input  logic [TIME_WIDTH-1:0]    now_time,
   input  logic [15:0]              enter_hold_time,
   input  logic [hrp_pkg::PAGE_WIDTH-1:0] repeat_page_step,
   output hrp_pkg::flags_type       next_flags,
   output logic [TIME_WIDTH-1:0]    next_last,
   output hrp_pkg::result_type      result
);
   import hrp_pkg::*;

   dir_type               dir;
   logic [8:0]            interval;
   logic [TIME_WIDTH-1:0] elapsed;
   logic [PAGE_WIDTH-1:0] step;
   result_type            repeat_res;

   always_comb begin
      if (held_time < TIME_WIDTH'(HELD_TIER_1)) begin
         interval = INTERVAL_0;
      end else if (held_time < TIME_WIDTH'(HELD_TIER_2)) begin
         interval = INTERVAL_1;
      end else if (held_time < TIME_WIDTH'(HELD_TIER_3)) begin
         interval = INTERVAL_2;
      end else begin
         interval = INTERVAL_3;
      end
   end

   assign dir     = (press_direction == DIR_INVALID) ? DIR_NONE : press_direction;
   assign elapsed = now_time - cur_last;
   assign step    = (repeat_page_step == '0) ? PAGE_WIDTH'(1) : repeat_page_step;

   always_comb begin
      repeat_res.turn  = 1'b1;
      repeat_res.dir   = cur_flags.dir;
      repeat_res.pages = step;
   end

   always_comb begin
      next_flags = cur_flags;
      next_last  = cur_last;
      result     = '0;
      if (press_edge && !cur_flags.pending && !cur_flags.active && dir != DIR_NONE) begin
         next_flags.pending = 1'b1;
         next_flags.dir     = dir;
      end else if (dir != cur_flags.dir) begin
         // direction mismatch: ignore sample
      end else if (release_edge || !button_down) begin
         next_flags = '0;
         next_last  = '0;
         if (cur_flags.pending && !cur_flags.active) begin
            result.turn  = 1'b1;
            result.dir   = cur_flags.dir;
            result.pages = PAGE_WIDTH'(1);
         end
      end else if (cur_flags.pending && held_time >= TIME_WIDTH'(enter_hold_time)) begin
         next_flags.pending = 1'b0;
         next_flags.active  = 1'b1;
         next_last          = now_time;
         result             = repeat_res;
      end else if (!cur_flags.active) begin
         // idle, or armed and still short of the entry time
      end else if (elapsed >= TIME_WIDTH'(interval)) begin
         next_last = now_time;
         result    = repeat_res;
      end
   end

endmodule

`default_nettype wire

/* src/hold_repeat_paging_fsm_core.sv */
// Top level of the hold-repeat paging block: input register, step logic, result register.
// Depends on hrp_pkg and hrp_step.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall press, release, down, direction, held, now
//   rsp      out        rsp_valid/rsp_stall turn_page, turn_direction, pages_to_move
//   csr      in         csr_write_enable    csr_index, csr_write_data
//
// One request per cycle while req_stall is low; results follow in request order.
// The state update and result computation sit between the input and result registers.
// rsp_stall backs up through the result register to req_stall in the same cycle.
// reset (synchronous) clears state and both valid flags and sets the CSRs to defaults.
`default_nettype none

module hold_repeat_paging_fsm_core #(
   parameter int TIME_WIDTH = hrp_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_press_edge,
   input  logic                     req_release_edge,
   input  logic                     req_button_down,
   input  logic [1:0]               req_press_direction,
   input  logic [31:0]              req_held_time,
   input  logic [31:0]              req_now_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_turn_page,
   output logic [1:0]               rsp_turn_direction,
   output logic [7:0]               rsp_pages_to_move,
   input  logic                     csr_write_enable,
   input  hrp_pkg::csr_index_type   csr_index,
   input  logic [hrp_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import hrp_pkg::*;

   logic [15:0]           enter_hold_time_ff;
   logic [PAGE_WIDTH-1:0] repeat_step_ff;

   logic        in_valid_ff, in_valid_in;
   logic        press_ff, release_ff, down_ff;
   dir_type     dir_ff;
   logic [31:0] held_ff, now_ff;

   flags_type             flags_ff;
   flags_type             flags_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic [TIME_WIDTH+31:0] held_wide, now_wide;
   logic                   accept, advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // fit the 32-bit sample times to the internal time width
   assign held_wide = {{TIME_WIDTH{1'b0}}, held_ff};
   assign now_wide  = {{TIME_WIDTH{1'b0}}, now_ff};

   hrp_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .cur_flags        (flags_ff),
      .cur_last         (last_ff),
      .press_edge       (press_ff),
      .release_edge     (release_ff),
      .button_down      (down_ff),
      .press_direction  (dir_ff),
      .held_time        (held_wide[TIME_WIDTH-1:0]),
      .now_time         (now_wide[TIME_WIDTH-1:0]),
      .enter_hold_time  (enter_hold_time_ff),
      .repeat_page_step (repeat_step_ff),
      .next_flags       (flags_in),
      .next_last        (last_in),
      .result           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_hold_time_ff <= ENTER_HOLD_RESET;
         repeat_step_ff     <= REPEAT_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENTER_HOLD_TIME:  enter_hold_time_ff <= csr_write_data[15:0];
            CSR_REPEAT_PAGE_STEP: repeat_step_ff     <= csr_write_data[PAGE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         last_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
            last_ff  <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         press_ff   <= req_press_edge;
         release_ff <= req_release_edge;
         down_ff    <= req_button_down;
         dir_ff     <= req_press_direction;
         held_ff    <= req_held_time;
         now_ff     <= req_now_time;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_turn_page      = rsp_ff.turn;
   assign rsp_turn_direction = rsp_ff.dir;
   assign rsp_pages_to_move  = rsp_ff.pages;

endmodule

`default_nettype wire

/* src/hrp_checker.sv */
// Port-level checks for hold_repeat_paging_fsm_core, attached by bind.
// Depends on hrp_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hrp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_turn_page,
   input logic [1:0] rsp_turn_direction,
   input logic [7:0] rsp_pages_to_move
);
   import hrp_pkg::*;

   `HRP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result valid after reset")

   `HRP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_turn_page, rsp_turn_direction, rsp_pages_to_move}), "stalled result changed")

   `HRP_ASSERT(a_idle_zero, clock, reset, rsp_valid && !rsp_turn_page |-> rsp_turn_direction == DIR_NONE && rsp_pages_to_move == 8'd0, "no-action result not all zero")

   `HRP_ASSERT(a_turn_sane, clock, reset, rsp_valid && rsp_turn_page |-> rsp_pages_to_move != 8'd0 && (rsp_turn_direction == DIR_FORWARD || rsp_turn_direction == DIR_BACKWARD), "turn without direction or pages")

endmodule

bind hold_repeat_paging_fsm_core hrp_checker u_hrp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_turn_page      (rsp_turn_page),
   .rsp_turn_direction (rsp_turn_direction),
   .rsp_pages_to_move  (rsp_pages_to_move)
);

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for hold_repeat_paging_fsm_core: press gestures, noise and register phases.
// Depends on hrp_pkg and the core RTL; a scoreboard class predicts every page-turn response.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hrp_pkg::*;

   typedef struct packed {
      logic       press;
      logic       rel;
      logic       down;
      dir_type    dir;
      logic [31:0] held;
      logic [31:0] now;
   } button_sample_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   class page_turn_scoreboard;
      logic [15:0] hold_entry;
      logic [7:0]  pages_per_step;
      logic        pending;
      logic        active;
      dir_type     held_dir;
      logic [31:0] last_step;
      result_type  expected_turns[$];
      int          errors;

      function new();
         hold_entry     = ENTER_HOLD_RESET;
         pages_per_step = REPEAT_STEP_RESET;
         pending        = 1'b0;
         active         = 1'b0;
         held_dir       = DIR_NONE;
         last_step      = '0;
         errors         = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] data);
         if (idx == CSR_ENTER_HOLD_TIME) hold_entry = data;
         else pages_per_step = data[7:0];
      endfunction

      function result_type predict_turn(button_sample_type s);
         dir_type     d;
         logic [31:0] elapsed;
         logic [8:0]  interval;
         logic [7:0]  step;
         result_type  r;
         d    = (s.dir == DIR_INVALID) ? DIR_NONE : s.dir;
         r    = '0;
         step = (pages_per_step == 8'd0) ? 8'd1 : pages_per_step;
         if (s.press && !pending && !active && d != DIR_NONE) begin
            pending  = 1'b1;
            held_dir = d;
            return r;
         end
         if (d != held_dir) return r;
         if (s.rel || !s.down) begin
            if (pending && !active) begin
               r.turn  = 1'b1;
               r.dir   = held_dir;
               r.pages = 8'd1;
            end
            pending   = 1'b0;
            active    = 1'b0;
            held_dir  = DIR_NONE;
            last_step = '0;
            return r;
         end
         if (pending && s.held >= {16'd0, hold_entry}) begin
            pending   = 1'b0;
            active    = 1'b1;
            last_step = s.now;
            r.turn    = 1'b1;
            r.dir     = held_dir;
            r.pages   = step;
            return r;
         end
         if (!active) return r;
         elapsed = s.now - last_step;
         if (s.held < HELD_TIER_1) interval = INTERVAL_0;
         else if (s.held < HELD_TIER_2) interval = INTERVAL_1;
         else if (s.held < HELD_TIER_3) interval = INTERVAL_2;
         else interval = INTERVAL_3;
         if (elapsed < interval) return r;
         last_step = s.now;
         r.turn    = 1'b1;
         r.dir     = held_dir;
         r.pages   = step;
         return r;
      endfunction

      function void note_sample(button_sample_type s);
         expected_turns.push_back(predict_turn(s));
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_turn(result_type got);
         result_type want;
         if (expected_turns.size() == 0) begin
            report($sformatf("response %p with no request outstanding", got));
            return;
         end
         want = expected_turns.pop_front();
         if (got.turn !== want.turn)
            report($sformatf("turn_page got %b want %b", got.turn, want.turn));
         if (got.dir !== want.dir)
            report($sformatf("turn_direction got %0d want %0d", got.dir, want.dir));
         if (got.pages !== want.pages)
            report($sformatf("pages_to_move got %0d want %0d", got.pages, want.pages));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_press_edge = 1'b0;
   logic        req_release_edge = 1'b0;
   logic        req_button_down = 1'b0;
   logic [1:0]  req_press_direction = DIR_NONE;
   logic [31:0] req_held_time = '0;
   logic [31:0] req_now_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_turn_page;
   logic [1:0]  rsp_turn_direction;
   logic [7:0]  rsp_pages_to_move;
   logic        csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_ENTER_HOLD_TIME;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   page_turn_scoreboard turns = new();

   int             burst_left = 0;
   int             samples_sent = 0;
   logic [15:0]    cur_hold = ENTER_HOLD_RESET;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_mode_left = 0;
   int             stall_phase = 0;

   hold_repeat_paging_fsm_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_press_edge      (req_press_edge),
      .req_release_edge    (req_release_edge),
      .req_button_down     (req_button_down),
      .req_press_direction (req_press_direction),
      .req_held_time       (req_held_time),
      .req_now_time        (req_now_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_turn_page       (rsp_turn_page),
      .rsp_turn_direction  (rsp_turn_direction),
      .rsp_pages_to_move   (rsp_pages_to_move),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            turns.note_sample('{req_press_edge, req_release_edge, req_button_down,
                                req_press_direction, req_held_time, req_now_time});
         if (rsp_valid && !rsp_stall)
            turns.check_turn('{rsp_turn_page, rsp_turn_direction, rsp_pages_to_move});
      end
   end

   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = stall_mode_type'($urandom_range(0, 3));
         stall_mode_left = $urandom_range(8, 80);
      end else begin
         stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_phase % 5) < 2;
      endcase
   end

   task automatic send_sample(input logic p, input logic r, input logic dn, input dir_type d,
                              input logic [31:0] h, input logic [31:0] n);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_valid           <= 1'b1;
      req_press_edge      <= p;
      req_release_edge    <= r;
      req_button_down     <= dn;
      req_press_direction <= d;
      req_held_time       <= h;
      req_now_time        <= n;
      do @(posedge clock); while (req_stall);
      burst_left--;
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (turns.expected_turns.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] hold, input logic [7:0] step);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ENTER_HOLD_TIME;
      csr_write_data   <= hold;
      @(posedge clock);
      csr_index        <= CSR_REPEAT_PAGE_STEP;
      csr_write_data   <= {8'($urandom), step};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      turns.set_reg(CSR_ENTER_HOLD_TIME, hold);
      turns.set_reg(CSR_REPEAT_PAGE_STEP, {8'd0, step});
      cur_hold = hold;
      @(posedge clock);
   endtask

   task automatic press_gesture();
      dir_type     d;
      dir_type     other;
      logic [31:0] t;
      logic [31:0] h;
      int          holds;
      int          dt;
      d = $urandom_range(0, 1) ? DIR_FORWARD : DIR_BACKWARD;
      case ($urandom_range(0, 3))
         0:       t = $urandom;
         1:       t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         default: t = $urandom_range(0, 100000);
      endcase
      case ($urandom_range(0, 6))
         0, 1:    h = '0;
         2:       h = HELD_TIER_1 - 16'd400;
         3:       h = HELD_TIER_2 - 16'd400;
         4:       h = HELD_TIER_3 - 16'd400;
         default: h = (cur_hold > 16'd300) ? {16'd0, cur_hold - 16'd300} : 32'd0;
      endcase
      send_sample(1'b1, 1'b0, 1'b1, d, h, t);
      holds = $urandom_range(0, 14);
      repeat (holds) begin
         dt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120) : $urandom_range(180, 380);
         t  = t + dt;
         h  = h + dt;
         case ($urandom_range(0, 15))
            0: begin
               do other = dir_type'($urandom_range(0, 3)); while (other == d);
               send_sample(1'b0, $urandom_range(0, 1), $urandom_range(0, 1), other, h, t);
            end
            1:       send_sample(1'b1, 1'b0, 1'b1, d, h, t);
            default: send_sample(1'b0, 1'b0, 1'b1, d, h, t);
         endcase
      end
      if ($urandom_range(0, 9) != 0) begin
         t = t + $urandom_range(0, 400);
         case ($urandom_range(0, 2))
            0:       send_sample(1'b0, 1'b1, 1'b1, d, h, t);
            1:       send_sample(1'b0, 1'b0, 1'b0, d, h, t);
            default: send_sample(1'b0, 1'b1, 1'b0, d, h, t);
         endcase
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) begin
         if ($urandom_range(0, 4) != 0) press_gesture();
         else send_sample($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                          dir_type'($urandom_range(0, 3)), $urandom, $urandom);
      end
   endtask

   initial begin
      logic [31:0] t0;
      t0 = 32'hFFFF_FF00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // short presses forward and backward, then direction invalid
      send_sample(1'b1, 1'b0, 1'b1, DIR_FORWARD, 32'd0, 32'd0);
      send_sample(1'b0, 1'b1, 1'b1, DIR_FORWARD, 32'd0, 32'd0);
      send_sample(1'b1, 1'b0, 1'b1, DIR_BACKWARD, 32'd100, 32'd5);
      send_sample(1'b0, 1'b0, 1'b0, DIR_BACKWARD, 32'd120, 32'd25);
      send_sample(1'b1, 1'b0, 1'b1, DIR_INVALID, 32'd0, 32'd0);
      send_sample(1'b0, 1'b1, 1'b0, DIR_INVALID, 32'd0, 32'd0);
      // hold into auto-repeat across time wrap and every interval tier
      send_sample(1'b1, 1'b0, 1'b1, DIR_FORWARD, 32'd0, t0);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd499, t0 + 32'd10);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd500, t0);
      send_sample(1'b1, 1'b0, 1'b1, DIR_FORWARD, 32'd4999, t0 + 32'd359);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd4999, t0 + 32'd360);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd5000, t0 + 32'd659);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd5000, t0 + 32'd660);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd10000, t0 + 32'd899);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd10000, t0 + 32'd900);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'd20000, t0 + 32'd1099);
      send_sample(1'b0, 1'b0, 1'b1, DIR_FORWARD, 32'hFFFF_FFFF, t0 + 32'd1100);
      send_sample(1'b0, 1'b0, 1'b1, DIR_BACKWARD, 32'hFFFF_FFFF, t0 + 32'd2000);
      send_sample(1'b0, 1'b1, 1'b1, DIR_NONE, 32'hFFFF_FFFF, t0 + 32'd2000);
      send_sample(1'b0, 1'b1, 1'b1, DIR_FORWARD, 32'hFFFF_FFFF, t0 + 32'd2000);
      // press and release together arms, then short press backward
      send_sample(1'b1, 1'b1, 1'b0, DIR_BACKWARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(1'b0, 1'b0, 1'b0, DIR_BACKWARD, 32'd0, 32'd0);
      wait_idle();

      run_random(80);
      wait_idle();
      configure(16'd0, 8'd1);
      run_random(80);
      wait_idle();
      configure(16'hFFFF, 8'd255);
      run_random(80);
      wait_idle();
      configure(16'd500, 8'd0);
      run_random(70);
      repeat (3) begin
         wait_idle();
         configure(($urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom)),
                   8'($urandom_range(1, 255)));
         run_random(80);
      end
      wait_idle();
      repeat (10) @(posedge clock);

      if (turns.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for responses");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
